// ===== rtl/drsfc_pkg.sv =====
// Package for the digital RGB frame capture block.
// Holds the frame geometry, register defaults, register indexes, the phase enum and the
// structs shared by the top level and the sequencer; the checker uses the geometry.
package drsfc_pkg;

	localparam int LINE_PIXELS = 640;
	localparam int FRAME_LINES = 200;

	localparam int SAMPLE_W = 5;
	localparam int COLOR_W  = 3;
	localparam int COL_W    = 10;
	localparam int ROW_W    = 8;
	localparam int PORCH_W  = 10;
	localparam int SKIP_W   = 11;
	localparam int CFG_W    = 10;
	localparam int CFG_IDX_W = 2;

	localparam int VSYNC_BIT = 4;
	localparam int HSYNC_BIT = 3;

	localparam logic [PORCH_W-1:0] VPORCH_RESET = PORCH_W'(36);
	localparam logic [PORCH_W-1:0] HPORCH_RESET = PORCH_W'(128);

	localparam logic [CFG_IDX_W-1:0] REG_VPORCH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HPORCH = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_PAIRED = CFG_IDX_W'(2);

	typedef enum logic [2:0] {
		PH_VLOW,
		PH_VHIGH,
		PH_PORCH_HLOW,
		PH_PORCH_HHIGH,
		PH_LINE_HLOW,
		PH_LINE_HHIGH,
		PH_SKIP,
		PH_CAPTURE
	} phase_t;

	typedef struct packed {
		logic [PORCH_W-1:0] vertical_porch_lines;
		logic [PORCH_W-1:0] horizontal_porch_samples;
		logic               paired_samples;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic [COLOR_W-1:0] pixel_color;
		logic [COL_W-1:0]   column;
		logic [ROW_W-1:0]   row;
		logic               frame_end;
		logic               sync_lost;
	} result_t;

endpackage

// ===== rtl/drsfc_seq.sv =====
// Capture sequencer: sync edge hunting, porch counting and pixel capture.
// Consumes one sample per step and produces at most one pixel result; uses drsfc_pkg.
module drsfc_seq
	import drsfc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [SAMPLE_W-1:0] sample,
	input  cfg_t                cfg,
	output result_t             res
);

	phase_t              phase_q, phase_d;
	logic [PORCH_W-1:0]  porch_cnt_q, porch_cnt_d;
	logic [ROW_W-1:0]    row_q, row_d;
	logic [COL_W-1:0]    col_q, col_d;
	logic [SKIP_W-1:0]   skip_q, skip_d;
	logic                toggle_q, toggle_d;

	logic                vs, hs;
	logic [PORCH_W-1:0]  porch_slots;
	logic [PORCH_W-1:0]  porch_inc;
	logic [SKIP_W-1:0]   skip_inc;
	logic                col_last, row_last;

	assign vs = sample[VSYNC_BIT];
	assign hs = sample[HSYNC_BIT];
	assign porch_slots = (cfg.horizontal_porch_samples > PORCH_W'(1)) ?
		cfg.horizontal_porch_samples - PORCH_W'(1) : '0;
	assign porch_inc = porch_cnt_q + PORCH_W'(1);
	assign skip_inc  = skip_q + SKIP_W'(1);
	assign col_last  = ({1'b0, col_q} + (COL_W+1)'(1)) >= (COL_W+1)'(LINE_PIXELS);
	assign row_last  = ({1'b0, row_q} + (ROW_W+1)'(1)) >= (ROW_W+1)'(FRAME_LINES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_VLOW;
			porch_cnt_q <= '0;
			row_q       <= '0;
			col_q       <= '0;
			skip_q      <= '0;
			toggle_q    <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			porch_cnt_q <= porch_cnt_d;
			row_q       <= row_d;
			col_q       <= col_d;
			skip_q      <= skip_d;
			toggle_q    <= toggle_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		porch_cnt_d = porch_cnt_q;
		row_d       = row_q;
		col_d       = col_q;
		skip_d      = skip_q;
		toggle_d    = toggle_q;
		res         = '0;
		unique case (phase_q)
			PH_VLOW: begin
				if (!vs) phase_d = PH_VHIGH;
			end
			PH_VHIGH: begin
				if (vs) begin
					porch_cnt_d = '0;
					row_d       = '0;
					phase_d     = (cfg.vertical_porch_lines == '0) ? PH_LINE_HLOW : PH_PORCH_HLOW;
				end
			end
			PH_PORCH_HLOW: begin
				if (!hs) phase_d = PH_PORCH_HHIGH;
			end
			PH_PORCH_HHIGH: begin
				if (hs) begin
					porch_cnt_d = porch_inc;
					if (porch_inc >= cfg.vertical_porch_lines || porch_inc == '0) begin
						phase_d = PH_LINE_HLOW;
					end else begin
						phase_d = PH_PORCH_HLOW;
					end
				end
			end
			PH_LINE_HLOW: begin
				if (!hs) phase_d = PH_LINE_HHIGH;
			end
			PH_LINE_HHIGH: begin
				if (hs) begin
					skip_d   = '0;
					toggle_d = 1'b0;
					if (porch_slots == '0) begin
						col_d   = '0;
						phase_d = PH_CAPTURE;
					end else begin
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (cfg.paired_samples && !toggle_q) begin
					toggle_d = 1'b1;
				end else begin
					toggle_d = 1'b0;
					skip_d   = skip_inc;
					if (skip_inc >= SKIP_W'(porch_slots)) begin
						col_d   = '0;
						phase_d = PH_CAPTURE;
					end
				end
			end
			PH_CAPTURE: begin
				if (cfg.paired_samples && !toggle_q) begin
					toggle_d = 1'b1;
				end else begin
					toggle_d   = 1'b0;
					res.valid  = 1'b1;
					res.column = col_q;
					res.row    = row_q;
					if (!vs || !hs) begin
						res.sync_lost = 1'b1;
						phase_d       = PH_VLOW;
					end else begin
						res.pixel_color = sample[COLOR_W-1:0];
						if (col_last) begin
							col_d = '0;
							if (row_last) begin
								res.frame_end = 1'b1;
								row_d         = '0;
								phase_d       = PH_VLOW;
							end else begin
								row_d   = row_q + ROW_W'(1);
								phase_d = PH_LINE_HLOW;
							end
						end else begin
							col_d = col_q + COL_W'(1);
						end
					end
				end
			end
			default: begin
				phase_d = PH_VLOW;
			end
		endcase
	end

endmodule

// ===== rtl/digital_rgb_sync_frame_capture.sv =====
// A sample is held in the input register; the sequencer step turns it into a pixel result that is
// registered in the result register. Throughput: one sample per clock while the output is not
// stalled, set by the sequencer step between the input register and the result register.
// Reset (asynchronous, active low) returns the sequencer to hunting for vsync low, empties
// both registers and restores the porch and pairing registers to their defaults.
// Depends on drsfc_pkg and drsfc_seq.
module digital_rgb_sync_frame_capture
	import drsfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [SAMPLE_W-1:0]  sample_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [COLOR_W-1:0]   pixel_color,
	output logic [COL_W-1:0]     column,
	output logic [ROW_W-1:0]     row,
	output logic                 frame_end,
	output logic                 sync_lost
);

	cfg_t                cfg_q;
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                out_free;
	logic                step;
	result_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vertical_porch_lines     <= VPORCH_RESET;
			cfg_q.horizontal_porch_samples <= HPORCH_RESET;
			cfg_q.paired_samples           <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_VPORCH: cfg_q.vertical_porch_lines     <= cfg_data[PORCH_W-1:0];
				REG_HPORCH: cfg_q.horizontal_porch_samples <= cfg_data[PORCH_W-1:0];
				REG_PAIRED: cfg_q.paired_samples           <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) sample_s1 <= sample_byte;
	end

	drsfc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sample (sample_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			pixel_color <= res.pixel_color;
			column      <= res.column;
			row         <= res.row;
			frame_end   <= res.frame_end;
			sync_lost   <= res.sync_lost;
		end
	end

endmodule

// ===== rtl/drsfc_checker.sv =====
// Port-level checker for the digital RGB frame capture block, bound to the top level.
// Uses drsfc_pkg for the frame geometry.
module drsfc_checker
	import drsfc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input logic [COLOR_W-1:0]  pixel_color,
	input logic [COL_W-1:0]    column,
	input logic [ROW_W-1:0]    row,
	input logic                frame_end,
	input logic                sync_lost
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(column) && $stable(row) && $stable(pixel_color)
			&& $stable(frame_end) && $stable(sync_lost))
		else $error("stalled result transfer changed");

	a_lost_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sync_lost |-> pixel_color == '0 && !frame_end)
		else $error("sync loss carries pixel data");

	a_frame_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> column == COL_W'(LINE_PIXELS - 1)
			&& row == ROW_W'(FRAME_LINES - 1))
		else $error("frame end away from last pixel");

endmodule

bind digital_rgb_sync_frame_capture drsfc_checker u_drsfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pixel_color (pixel_color),
	.column      (column),
	.row         (row),
	.frame_end   (frame_end),
	.sync_lost   (sync_lost)
);
